/* src/dlr_pkg.sv */
// ----------------------------------------------------------------------------
// dlr_pkg
// Shared constants and helpers of the local DNS responder.
// ----------------------------------------------------------------------------
package dlr_pkg;

  localparam logic [1:0] FUNC_PKT    = 2'd0;
  localparam logic [1:0] FUNC_CHAR   = 2'd1;
  localparam logic [1:0] FUNC_COMMIT = 2'd2;

  localparam logic [1:0] ROUTE_REPLY = 2'd0;
  localparam logic [1:0] ROUTE_FWD   = 2'd1;
  localparam logic [1:0] ROUTE_DROP  = 2'd2;

  localparam int unsigned HDR_BYTES = 12;
  localparam int unsigned COUNT_MAX = 511;
  localparam logic [15:0] NAME_PTR  = 16'hC00C;
  localparam logic [7:0]  FLAGS_HI  = 8'h85;
  localparam logic [7:0]  RCODE_NX  = 8'h03;
  localparam logic [7:0]  DOT_CHAR  = 8'h2E;
  localparam logic [7:0]  SPACE_MAX = 8'd32;

  function automatic logic [7:0] dotted(input logic [7:0] b);
    return (b <= SPACE_MAX) ? DOT_CHAR : b;
  endfunction

endpackage

/* src/dlr_ram.sv */
// ----------------------------------------------------------------------------
// dlr_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module dlr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* src/dns_local_responder_unit.sv */
// ----------------------------------------------------------------------------
// dns_local_responder_unit
// Local DNS responder: host table lookup on buffered query packets.
// ----------------------------------------------------------------------------
// Table characters and commits are written straight into the name and meta
// RAMs. Packet bytes are taken one per cycle into the packet RAM while the
// block is idle. After the last byte the block stalls its input: it scans
// for the name terminator, visits the table slots and compares name bytes
// (packet and name RAMs read in parallel), then emits the bytes and pushes
// the output words; each step has a read state and a check state, as the
// RAM read is registered. A dropped packet goes straight to the push.
module dns_local_responder_unit
  import dlr_pkg::*;
#(
  parameter int TABLE_ENTRIES = 256,
  parameter int NAME_BYTES    = 64,
  parameter int PACKET_BYTES  = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic [7:0]  in_entry_index,
  input  logic [6:0]  in_char_pos,
  input  logic [31:0] in_entry_address,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_data,
  output logic [3:0]  out_bytes,
  output logic        out_last,
  output logic [1:0]  out_route,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int XW  = ((IW > 8) ? IW : 8) + 1;
  localparam int SW  = $clog2(TABLE_ENTRIES + 1);
  localparam int NLW = $clog2(NAME_BYTES + 1);
  localparam int NAW = $clog2(TABLE_ENTRIES * NAME_BYTES);
  localparam int PAW = $clog2(PACKET_BYTES);
  localparam int MW  = NLW + 32;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_SCAN_RD = 4'd1;
  localparam logic [3:0] S_SCAN_CK = 4'd2;
  localparam logic [3:0] S_SLOT_RD = 4'd3;
  localparam logic [3:0] S_SLOT_CK = 4'd4;
  localparam logic [3:0] S_CHR_RD  = 4'd5;
  localparam logic [3:0] S_CHR_CK  = 4'd6;
  localparam logic [3:0] S_EMIT_RD = 4'd7;
  localparam logic [3:0] S_EMIT_WR = 4'd8;
  localparam logic [3:0] S_PUSH    = 4'd9;

  localparam logic [8:0] HDR9 = 9'(HDR_BYTES);

  logic [3:0]  state_r, state_nxt;
  logic [8:0]  count_r, count_nxt;
  logic        ovf_r, ovf_nxt;
  logic [31:0] ttl_r;
  logic [TABLE_ENTRIES-1:0] valid_r;
  logic [8:0]  len_r, len_nxt;
  logic [8:0]  term_r, term_nxt;
  logic [NLW-1:0] nlen_r, nlen_nxt;
  logic [NLW-1:0] k_r, k_nxt;
  logic [SW-1:0]  s_r, s_nxt;
  logic [NAW-1:0] base_r, base_nxt;
  logic [31:0] haddr_r, haddr_nxt;
  logic        good_r, good_nxt;
  logic [1:0]  route_r, route_nxt;
  logic [8:0]  epos_r, epos_nxt;
  logic [8:0]  elen_r, elen_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic        ov_r, ov_nxt;
  logic [63:0] od_r, od_nxt;
  logic [3:0]  ob_r, ob_nxt;
  logic        ol_r, ol_nxt;
  logic [1:0]  or_r, or_nxt;

  logic fire;
  logic [XW-1:0] idx_x;
  logic pkt_we, pkt_re, name_we, name_re, meta_re, meta_we;
  logic [PAW-1:0] pkt_raddr;
  logic [NAW-1:0] name_raddr, name_waddr;
  logic [7:0] pkt_rd, name_rd;
  logic [MW-1:0] meta_rd;
  logic [NLW-1:0] len_sat;
  logic [8:0] nlen_w, qend;
  logic [7:0] ebyte;
  logic [3:0] aj;

  assign fire  = in_valid && !in_stall;
  assign idx_x = XW'(in_entry_index);
  assign in_stall = (state_r != S_IDLE);

  assign pkt_we  = fire && (in_func == FUNC_PKT) && (count_r < 9'(PACKET_BYTES));
  assign name_we = fire && (in_func == FUNC_CHAR) && (idx_x < XW'(TABLE_ENTRIES))
                   && (32'(in_char_pos) < 32'(NAME_BYTES));
  assign meta_we = fire && (in_func == FUNC_COMMIT) && (idx_x < XW'(TABLE_ENTRIES));
  assign name_waddr = NAW'(idx_x[IW-1:0] * NAME_BYTES + in_char_pos);
  assign len_sat = (32'(in_char_pos) > 32'(NAME_BYTES)) ? NLW'(NAME_BYTES)
                                                        : NLW'(in_char_pos);

  dlr_ram #(.WIDTH(8), .DEPTH(PACKET_BYTES)) u_pkt (
    .clk(clk), .we(pkt_we), .waddr(count_r[PAW-1:0]), .wdata(in_data_byte),
    .re(pkt_re), .raddr(pkt_raddr), .rdata(pkt_rd));

  dlr_ram #(.WIDTH(8), .DEPTH(TABLE_ENTRIES * NAME_BYTES)) u_name (
    .clk(clk), .we(name_we), .waddr(name_waddr), .wdata(in_data_byte),
    .re(name_re), .raddr(name_raddr), .rdata(name_rd));

  dlr_ram #(.WIDTH(MW), .DEPTH(TABLE_ENTRIES)) u_meta (
    .clk(clk), .we(meta_we), .waddr(idx_x[IW-1:0]), .wdata({len_sat, in_entry_address}),
    .re(meta_re), .raddr(s_r[IW-1:0]), .rdata(meta_rd));

  assign nlen_w = (term_r > HDR9) ? term_r - HDR9 - 9'd1 : 9'd0;
  assign qend   = term_r + 9'd5;
  assign aj     = 4'(epos_r - qend);

  always_comb begin
    ebyte = pkt_rd;
    if (route_r == ROUTE_REPLY) begin
      if (epos_r < HDR9) begin
        unique case (epos_r[3:0])
          4'd0, 4'd1: ebyte = pkt_rd;
          4'd2:       ebyte = FLAGS_HI;
          4'd3:       ebyte = good_r ? 8'h00 : RCODE_NX;
          4'd5:       ebyte = 8'h01;
          4'd7:       ebyte = {7'd0, good_r};
          default:    ebyte = 8'h00;
        endcase
      end else if (epos_r >= qend) begin
        unique case (aj)
          4'd0:    ebyte = NAME_PTR[15:8];
          4'd1:    ebyte = NAME_PTR[7:0];
          4'd3:    ebyte = 8'h01;
          4'd5:    ebyte = 8'h01;
          4'd6:    ebyte = ttl_r[31:24];
          4'd7:    ebyte = ttl_r[23:16];
          4'd8:    ebyte = ttl_r[15:8];
          4'd9:    ebyte = ttl_r[7:0];
          4'd11:   ebyte = 8'h04;
          4'd12:   ebyte = haddr_r[31:24];
          4'd13:   ebyte = haddr_r[23:16];
          4'd14:   ebyte = haddr_r[15:8];
          4'd15:   ebyte = haddr_r[7:0];
          default: ebyte = 8'h00;
        endcase
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    len_nxt   = len_r;
    term_nxt  = term_r;
    nlen_nxt  = nlen_r;
    k_nxt     = k_r;
    s_nxt     = s_r;
    base_nxt  = base_r;
    haddr_nxt = haddr_r;
    good_nxt  = good_r;
    route_nxt = route_r;
    epos_nxt  = epos_r;
    elen_nxt  = elen_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    ov_nxt    = ov_r && out_stall;
    od_nxt    = od_r;
    ob_nxt    = ob_r;
    ol_nxt    = ol_r;
    or_nxt    = or_r;
    pkt_re    = 1'b0;
    pkt_raddr = term_r[PAW-1:0];
    name_re   = 1'b0;
    name_raddr = base_r + NAW'(k_r);
    meta_re   = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (fire && in_func == FUNC_PKT) begin
          if (count_r >= 9'(PACKET_BYTES)) ovf_nxt = 1'b1;
          if (count_r < 9'(COUNT_MAX)) count_nxt = count_r + 9'd1;
          if (in_last_byte) begin
            len_nxt   = (count_r < 9'(COUNT_MAX)) ? count_r + 9'd1 : count_r;
            count_nxt = 9'd0;
            ovf_nxt   = 1'b0;
            acc_nxt   = '0;
            cnt_nxt   = 4'd0;
            epos_nxt  = 9'd0;
            if (ovf_r || count_r >= 9'(PACKET_BYTES)) begin
              route_nxt = ROUTE_DROP;
              cnt_nxt   = 4'd1;
              epos_nxt  = 9'd1;
              elen_nxt  = 9'd1;
              state_nxt = S_PUSH;
            end else begin
              term_nxt  = HDR9;
              state_nxt = S_SCAN_RD;
            end
          end
        end
      end
      S_SCAN_RD: begin
        if (term_r >= len_r) begin
          route_nxt = ROUTE_FWD;
          elen_nxt  = len_r;
          state_nxt = S_EMIT_RD;
        end else begin
          pkt_re    = 1'b1;
          state_nxt = S_SCAN_CK;
        end
      end
      S_SCAN_CK: begin
        if (pkt_rd != 8'h00) begin
          term_nxt  = term_r + 9'd1;
          state_nxt = S_SCAN_RD;
        end else if (qend > len_r || nlen_w > 9'(NAME_BYTES)) begin
          route_nxt = ROUTE_FWD;
          elen_nxt  = len_r;
          state_nxt = S_EMIT_RD;
        end else begin
          nlen_nxt  = NLW'(nlen_w);
          s_nxt     = '0;
          base_nxt  = '0;
          state_nxt = S_SLOT_RD;
        end
      end
      S_SLOT_RD: begin
        if (s_r == SW'(TABLE_ENTRIES) || !valid_r[s_r[IW-1:0]]) begin
          route_nxt = ROUTE_FWD;
          elen_nxt  = len_r;
          state_nxt = S_EMIT_RD;
        end else begin
          meta_re   = 1'b1;
          state_nxt = S_SLOT_CK;
        end
      end
      S_SLOT_CK: begin
        haddr_nxt = meta_rd[31:0];
        k_nxt     = '0;
        if (meta_rd[MW-1:32] != nlen_r) begin
          s_nxt     = s_r + SW'(1);
          base_nxt  = base_r + NAW'(NAME_BYTES);
          state_nxt = S_SLOT_RD;
        end else begin
          state_nxt = S_CHR_RD;
        end
      end
      S_CHR_RD: begin
        if (k_r == nlen_r) begin
          route_nxt = ROUTE_REPLY;
          good_nxt  = (haddr_r != 32'd0);
          elen_nxt  = qend + ((haddr_r != 32'd0) ? 9'd16 : 9'd0);
          state_nxt = S_EMIT_RD;
        end else begin
          pkt_re    = 1'b1;
          pkt_raddr = PAW'(HDR9 + 9'd1 + 9'(k_r));
          name_re   = 1'b1;
          state_nxt = S_CHR_CK;
        end
      end
      S_CHR_CK: begin
        if (name_rd == dotted(pkt_rd)) begin
          k_nxt     = k_r + NLW'(1);
          state_nxt = S_CHR_RD;
        end else begin
          s_nxt     = s_r + SW'(1);
          base_nxt  = base_r + NAW'(NAME_BYTES);
          state_nxt = S_SLOT_RD;
        end
      end
      S_EMIT_RD: begin
        pkt_re    = 1'b1;
        pkt_raddr = epos_r[PAW-1:0];
        state_nxt = S_EMIT_WR;
      end
      S_EMIT_WR: begin
        acc_nxt[63 - 8 * cnt_r[2:0] -: 8] = ebyte;
        cnt_nxt  = cnt_r + 4'd1;
        epos_nxt = epos_r + 9'd1;
        if (cnt_r == 4'd7 || epos_r + 9'd1 == elen_r) begin
          state_nxt = S_PUSH;
        end else begin
          state_nxt = S_EMIT_RD;
        end
      end
      S_PUSH: begin
        if (!ov_r || !out_stall) begin
          ov_nxt  = 1'b1;
          od_nxt  = acc_r;
          ob_nxt  = cnt_r;
          ol_nxt  = (epos_r == elen_r);
          or_nxt  = route_r;
          acc_nxt = '0;
          cnt_nxt = 4'd0;
          state_nxt = (epos_r == elen_r) ? S_IDLE : S_EMIT_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= 9'd0;
      ovf_r   <= 1'b0;
      ttl_r   <= 32'd600;
      valid_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      ov_r    <= ov_nxt;
      if (psel && penable && pwrite && !paddr) ttl_r <= pwdata;
      if (meta_we) valid_r[idx_x[IW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    len_r   <= len_nxt;
    term_r  <= term_nxt;
    nlen_r  <= nlen_nxt;
    k_r     <= k_nxt;
    s_r     <= s_nxt;
    base_r  <= base_nxt;
    haddr_r <= haddr_nxt;
    good_r  <= good_nxt;
    route_r <= route_nxt;
    epos_r  <= epos_nxt;
    elen_r  <= elen_nxt;
    acc_r   <= acc_nxt;
    cnt_r   <= cnt_nxt;
    od_r    <= od_nxt;
    ob_r    <= ob_nxt;
    ol_r    <= ol_nxt;
    or_r    <= or_nxt;
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;
  assign out_bytes = ob_r;
  assign out_last  = ol_r;
  assign out_route = or_r;
  assign prdata    = paddr ? 32'd0 : ttl_r;
  assign pready    = 1'b1;

endmodule

/* src/dlr_chk.sv */
// ----------------------------------------------------------------------------
// dlr_chk
// Port-level checks of the local DNS responder result channel.
// ----------------------------------------------------------------------------
module dlr_chk
  import dlr_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [63:0] out_data,
  input logic [3:0]  out_bytes,
  input logic        out_last,
  input logic [1:0]  out_route
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data) && $stable(out_bytes))
    else $error("stalled result changed");

  a_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_bytes != 4'd0 && out_bytes <= 4'd8)
    else $error("byte count out of range");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> out_bytes == 4'd8)
    else $error("short word before end of packet");

  a_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_route == ROUTE_DROP |-> out_last && out_bytes == 4'd1 && out_data == 64'd0)
    else $error("malformed drop marker");

endmodule

bind dns_local_responder_unit dlr_chk u_dlr_chk (.*);
